>>> design/rmq_pkg.sv
// Shared constants and types for the rotation matrix to quaternion unit.
`default_nettype none
package rmq_pkg;

	localparam int FRAC_BITS_DEF = 14;
	localparam int IN_W = 16;
	localparam int IN_N = 9;
	localparam int OUT_W = 16;
	localparam int MAG_W = 17;
	localparam int TERM_W = 17;
	localparam int SUM_W = 18;

	localparam logic [1:0] IDX_W = 2'd0;
	localparam logic [1:0] IDX_X = 2'd1;
	localparam logic [1:0] IDX_Y = 2'd2;
	localparam logic [1:0] IDX_Z = 2'd3;

	// side data that rides along the root and divide pipelines
	typedef struct packed {
		logic [1:0]              idx;
		logic                    degen;
		logic [2:0]              neg;
		logic [2:0][MAG_W-1:0]   mag;
	} rmq_pay_t;

endpackage
`default_nettype wire

>>> design/rotation_matrix_to_quaternion_unit.sv
// Top level: pipelined rotation matrix to quaternion conversion.
//
// Input stream: one 3x3 matrix per transfer on s_axis, nine signed fixed-point
// entries with FRAC_BITS fraction bits. Output stream: one quaternion per
// transfer on m_axis, with the chosen largest component and a degenerate flag
// in tuser.
// Throughput: one matrix per cycle while the receiver is not stalling. RTW is
// the root width (one stage per root bit of the square root) and NW the
// quotient width (one stage per quotient bit, three dividers side by side).
// With FRAC_BITS = 14, RTW = 17 and NW = 32.
// Reset clears all valid bits; no transfer is in flight after reset.
// When the receiver stalls, the whole pipeline holds and s_axis_tready drops
// only while the output register holds a result that is not taken.
`default_nettype none
module rotation_matrix_to_quaternion_unit #(
	parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     s_axis_tvalid,
	output logic                                          s_axis_tready,
	// m11, m12, m13, m21, m22, m23, m31, m32, m33 (16 bits each)
	input  wire logic [rmq_pkg::IN_N*rmq_pkg::IN_W-1:0]   s_axis_tdata,
	output logic                                          m_axis_tvalid,
	input  wire logic                                     m_axis_tready,
	// quat_x, quat_y, quat_z, quat_w (16 bits each)
	output logic [4*rmq_pkg::OUT_W-1:0]                   m_axis_tdata,
	// largest_index (2 bits), degenerate (1 bit)
	output logic [2:0]                                    m_axis_tuser
);
	import rmq_pkg::*;

	localparam int UW = ((FRAC_BITS > SUM_W - 1) ? FRAC_BITS : SUM_W - 1) + 2;
	localparam int RW0 = UW + FRAC_BITS;
	localparam int RW = RW0 + (RW0 % 2);
	localparam int RTW = RW / 2;
	localparam int SRW = RTW + 2;
	localparam int NW = MAG_W + FRAC_BITS + 1;

	logic adv;
	assign adv = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;

	// stage 1: diagonal sums and off-diagonal terms
	logic signed [IN_W-1:0] m [IN_N];
	logic valid_s1;
	logic signed [SUM_W-1:0] sum_s1 [4];
	logic signed [TERM_W-1:0] term_s1 [6];

	always_comb begin
		for (int i = 0; i < IN_N; i++) begin
			m[i] = s_axis_tdata[i*IN_W +: IN_W];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s1[0] <= SUM_W'(m[0]) + SUM_W'(m[4]) + SUM_W'(m[8]);
			sum_s1[1] <= SUM_W'(m[0]) - SUM_W'(m[4]) - SUM_W'(m[8]);
			sum_s1[2] <= SUM_W'(m[4]) - SUM_W'(m[0]) - SUM_W'(m[8]);
			sum_s1[3] <= SUM_W'(m[8]) - SUM_W'(m[0]) - SUM_W'(m[4]);
			term_s1[0] <= TERM_W'(m[5]) - TERM_W'(m[7]);   // m23-m32
			term_s1[1] <= TERM_W'(m[6]) - TERM_W'(m[2]);   // m31-m13
			term_s1[2] <= TERM_W'(m[1]) - TERM_W'(m[3]);   // m12-m21
			term_s1[3] <= TERM_W'(m[1]) + TERM_W'(m[3]);   // m12+m21
			term_s1[4] <= TERM_W'(m[6]) + TERM_W'(m[2]);   // m31+m13
			term_s1[5] <= TERM_W'(m[5]) + TERM_W'(m[7]);   // m23+m32
		end
	end

	// stage 2: pick largest sum, form radicand, select the three terms
	logic signed [SUM_W-1:0] best;
	logic [1:0] idx;
	logic signed [UW:0] s_full;
	logic degen;
	logic signed [TERM_W-1:0] dsel [3];
	rmq_pay_t pay_c;

	always_comb begin
		best = sum_s1[0];
		idx = IDX_W;
		if (sum_s1[1] > best) begin
			best = sum_s1[1];
			idx = IDX_X;
		end
		if (sum_s1[2] > best) begin
			best = sum_s1[2];
			idx = IDX_Y;
		end
		if (sum_s1[3] > best) begin
			best = sum_s1[3];
			idx = IDX_Z;
		end
		s_full = (UW+1)'(best) + ((UW+1)'(1) << FRAC_BITS);
		degen = (s_full <= 0);
		case (idx)
			IDX_W: begin
				dsel[0] = term_s1[0];
				dsel[1] = term_s1[1];
				dsel[2] = term_s1[2];
			end
			IDX_X: begin
				dsel[0] = term_s1[0];
				dsel[1] = term_s1[3];
				dsel[2] = term_s1[4];
			end
			IDX_Y: begin
				dsel[0] = term_s1[1];
				dsel[1] = term_s1[3];
				dsel[2] = term_s1[5];
			end
			default: begin
				dsel[0] = term_s1[2];
				dsel[1] = term_s1[4];
				dsel[2] = term_s1[5];
			end
		endcase
		pay_c.idx = idx;
		pay_c.degen = degen;
		for (int l = 0; l < 3; l++) begin
			pay_c.neg[l] = dsel[l][TERM_W-1];
			pay_c.mag[l] = dsel[l][TERM_W-1] ? MAG_W'(-dsel[l]) : MAG_W'(dsel[l]);
		end
	end

	// square root pipeline: index 0 is stage 2, one root bit per stage
	logic               sq_v_s   [RTW+1];
	logic [RW-1:0]      sq_x_s   [RTW+1];
	logic [SRW-1:0]     sq_rem_s [RTW+1];
	logic [RTW-1:0]     sq_r_s   [RTW+1];
	rmq_pay_t           sq_pay_s [RTW+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_v_s[0] <= 1'b0;
		end else if (adv) begin
			sq_v_s[0] <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sq_x_s[0] <= degen ? '0 : (RW'(s_full[UW-1:0]) << FRAC_BITS);
			sq_rem_s[0] <= '0;
			sq_r_s[0] <= '0;
			sq_pay_s[0] <= pay_c;
		end
	end

	for (genvar k = 0; k < RTW; k++) begin : g_sqrt
		logic [SRW+1:0] rsh;
		logic [SRW+1:0] trial;
		logic ge;

		always_comb begin
			rsh = {sq_rem_s[k], sq_x_s[k][RW-1 -: 2]};
			trial = {SRW'(sq_r_s[k]), 2'b01};
			ge = (rsh >= trial);
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_v_s[k+1] <= 1'b0;
			end else if (adv) begin
				sq_v_s[k+1] <= sq_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				sq_x_s[k+1] <= sq_x_s[k] << 2;
				sq_rem_s[k+1] <= ge ? SRW'(rsh - trial) : SRW'(rsh);
				sq_r_s[k+1] <= {sq_r_s[k][RTW-2:0], ge};
				sq_pay_s[k+1] <= sq_pay_s[k];
			end
		end
	end

	// divide pipeline: three lanes, one quotient bit per stage
	logic                   dv_v_s   [NW+1];
	logic [2:0][NW-1:0]     dv_n_s   [NW+1];
	logic [2:0][SRW-1:0]    dv_rem_s [NW+1];
	logic [2:0][NW-1:0]     dv_q_s   [NW+1];
	logic [RTW-1:0]         dv_r_s   [NW+1];
	rmq_pay_t               dv_pay_s [NW+1];

	// entry: numerator is mag * 2^F + r so the quotient rounds half away from zero
	always_comb begin
		dv_v_s[0] = sq_v_s[RTW];
		dv_r_s[0] = sq_r_s[RTW];
		dv_pay_s[0] = sq_pay_s[RTW];
		for (int l = 0; l < 3; l++) begin
			dv_n_s[0][l] = (NW'(sq_pay_s[RTW].mag[l]) << FRAC_BITS) + NW'(sq_r_s[RTW]);
			dv_rem_s[0][l] = '0;
			dv_q_s[0][l] = '0;
		end
	end

	for (genvar j = 0; j < NW; j++) begin : g_div
		logic [2:0][SRW:0] rsh;
		logic [SRW:0] dsor;
		logic [2:0] ge;

		always_comb begin
			dsor = {2'b00, dv_r_s[j], 1'b0};
			for (int l = 0; l < 3; l++) begin
				rsh[l] = {dv_rem_s[j][l], dv_n_s[j][l][NW-1]};
				ge[l] = (rsh[l] >= dsor);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v_s[j+1] <= 1'b0;
			end else if (adv) begin
				dv_v_s[j+1] <= dv_v_s[j];
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				for (int l = 0; l < 3; l++) begin
					dv_n_s[j+1][l] <= dv_n_s[j][l] << 1;
					dv_rem_s[j+1][l] <= ge[l] ? SRW'(rsh[l] - dsor) : SRW'(rsh[l]);
					dv_q_s[j+1][l] <= {dv_q_s[j][l][NW-2:0], ge[l]};
				end
				dv_r_s[j+1] <= dv_r_s[j];
				dv_pay_s[j+1] <= dv_pay_s[j];
			end
		end
	end

	// output stage: saturate, place lanes around the chosen component, zero all if degenerate
	function automatic logic [OUT_W-1:0] sat_lane(input logic [NW-1:0] q, input logic neg);
		logic [OUT_W-1:0] res;
		if (!neg) begin
			res = (q > NW'(32767)) ? OUT_W'(32767) : q[OUT_W-1:0];
		end else begin
			res = (q > NW'(32768)) ? OUT_W'(32768) : OUT_W'(-q[OUT_W-1:0]);
		end
		return res;
	endfunction

	rmq_pay_t fp;
	logic [RTW:0] big_full;
	logic [OUT_W-1:0] big;
	logic [OUT_W-1:0] lane [3];
	logic [OUT_W-1:0] comp [4];

	always_comb begin
		fp = dv_pay_s[NW];
		big_full = ({1'b0, dv_r_s[NW]} + (RTW+1)'(1)) >> 1;
		big = (big_full > (RTW+1)'(32767)) ? OUT_W'(32767) : big_full[OUT_W-1:0];
		for (int l = 0; l < 3; l++) begin
			lane[l] = sat_lane(dv_q_s[NW][l], fp.neg[l]);
		end
		case (fp.idx)
			IDX_W: begin
				comp[0] = big;
				comp[1] = lane[0];
				comp[2] = lane[1];
				comp[3] = lane[2];
			end
			IDX_X: begin
				comp[0] = lane[0];
				comp[1] = big;
				comp[2] = lane[1];
				comp[3] = lane[2];
			end
			IDX_Y: begin
				comp[0] = lane[0];
				comp[1] = lane[1];
				comp[2] = big;
				comp[3] = lane[2];
			end
			default: begin
				comp[0] = lane[0];
				comp[1] = lane[1];
				comp[2] = lane[2];
				comp[3] = big;
			end
		endcase
		if (fp.degen) begin
			for (int c = 0; c < 4; c++) begin
				comp[c] = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= dv_v_s[NW];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= {comp[0], comp[3], comp[2], comp[1]};
			m_axis_tuser <= {fp.degen, fp.idx};
		end
	end

endmodule
`default_nettype wire
